### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the classifier.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset disable.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Clocked boolean that must never hold.
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error(msg);

`endif

### hw/rtl/ipc_pkg.sv
// Package of the integer property classifier: width default, state types,
// unit status struct and divisor constants. Depends on nothing.
`timescale 1ns / 1ps

package ipc_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned FIRST_DIVISOR   = 3;
  localparam int unsigned DIVISOR_STEP    = 2;
  localparam int unsigned SMALL_PRIME_LO  = 2;
  localparam int unsigned SMALL_PRIME_HI  = 3;

  typedef enum logic {
    TOP_IDLE,
    TOP_RUN
  } top_state_e;

  typedef enum logic {
    FIB_IDLE,
    FIB_RUN
  } fib_state_e;

  typedef enum logic [1:0] {
    PR_IDLE,
    PR_ISSUE,
    PR_WAIT
  } prime_state_e;

  typedef struct packed {
    logic busy;
    logic flag;
  } unit_stat_t;

endpackage

### hw/rtl/ipc_div.sv
// Radix-2 serial divider: one dividend bit shifted in per cycle.
// Standalone; used by ipc_prime.
`timescale 1ns / 1ps

module ipc_div #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);

  localparam int unsigned CW = $clog2(W);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  dvd_q, dvd_d;
  logic [W-1:0]  dsr_q, dsr_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  shifted;
  logic          fits;

  always_comb begin
    shifted = {rem_q[W-2:0], dvd_q[W-1]};
    fits    = shifted >= dsr_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    dsr_d   = dsr_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? shifted - dsr_q : shifted;
      quo_d = {quo_q[W-2:0], fits};
      dvd_d = {dvd_q[W-2:0], 1'b0};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

### hw/rtl/ipc_fib.sv
// Bit-serial Fibonacci membership test: rotates the pair and the value
// LSB first, one bit per cycle. Depends on ipc_pkg.
`timescale 1ns / 1ps

module ipc_fib import ipc_pkg::*; #(
  parameter int unsigned W = VALUE_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] value_i,
  output unit_stat_t   stat_o
);

  localparam int unsigned CW = $clog2(W + 1);

  fib_state_e    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W:0]    a_q, a_d;
  logic [W:0]    b_q, b_d;
  logic [W:0]    n_q, n_d;
  logic          carry_q, carry_d;
  logic          lt_q, lt_d;
  logic          ne_q, ne_d;
  logic          flag_q, flag_d;
  logic          sum_bit;
  logic          carry_nx;
  logic          lt_nx;
  logic          ne_nx;
  logic          last;

  always_comb begin
    sum_bit  = a_q[0] ^ b_q[0] ^ carry_q;
    carry_nx = (a_q[0] & b_q[0]) | (carry_q & (a_q[0] ^ b_q[0]));
    lt_nx    = (~b_q[0] & n_q[0]) | (~(b_q[0] ^ n_q[0]) & lt_q);
    ne_nx    = ne_q | (b_q[0] ^ n_q[0]);
    last     = cnt_q == CW'(W);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      FIB_IDLE: begin
        if (start_i && !value_i[W-1]) begin
          state_d = FIB_RUN;
        end
      end
      FIB_RUN: begin
        if (last && !lt_nx) begin
          state_d = FIB_IDLE;
        end
      end
      default: state_d = FIB_IDLE;
    endcase
  end

  always_comb begin
    cnt_d   = cnt_q;
    a_d     = a_q;
    b_d     = b_q;
    n_d     = n_q;
    carry_d = carry_q;
    lt_d    = lt_q;
    ne_d    = ne_q;
    flag_d  = flag_q;
    if (state_q == FIB_IDLE) begin
      if (start_i) begin
        cnt_d   = '0;
        a_d     = (W + 1)'(1);
        b_d     = '0;
        n_d     = {1'b0, value_i};
        carry_d = 1'b0;
        lt_d    = 1'b0;
        ne_d    = 1'b0;
        flag_d  = 1'b0;
      end
    end else begin
      a_d = {b_q[0], a_q[W:1]};
      b_d = {sum_bit, b_q[W:1]};
      n_d = {n_q[0], n_q[W:1]};
      if (last) begin
        cnt_d   = '0;
        carry_d = 1'b0;
        lt_d    = 1'b0;
        ne_d    = 1'b0;
        flag_d  = ~ne_nx;
      end else begin
        cnt_d   = cnt_q + CW'(1);
        carry_d = carry_nx;
        lt_d    = lt_nx;
        ne_d    = ne_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIB_IDLE;
      cnt_q   <= '0;
      carry_q <= 1'b0;
      lt_q    <= 1'b0;
      ne_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      carry_q <= carry_d;
      lt_q    <= lt_d;
      ne_q    <= ne_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    n_q    <= n_d;
    flag_q <= flag_d;
  end

  always_comb begin
    stat_o.busy = state_q == FIB_RUN;
    stat_o.flag = flag_q;
  end

endmodule

### hw/rtl/ipc_prime.sv
// Trial-division primality sequencer: odd divisors from three upward,
// one serial divide each, stop once the quotient drops below the divisor
// or the remainder is zero. Depends on ipc_pkg and ipc_div.
`timescale 1ns / 1ps

module ipc_prime import ipc_pkg::*; #(
  parameter int unsigned W = VALUE_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] value_i,
  output unit_stat_t   stat_o
);

  prime_state_e state_q, state_d;
  logic [W-1:0] n_q, n_d;
  logic [W-1:0] d_q, d_d;
  logic         flag_q, flag_d;
  logic         quick;
  logic         div_start;
  logic         div_done;
  logic [W-1:0] quot;
  logic [W-1:0] rem;
  logic         quot_lt;
  logic         rem_zero;

  ipc_div #(
    .W(W)
  ) u_ipc_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(n_q),
    .divisor_i (d_q),
    .done_o    (div_done),
    .quot_o    (quot),
    .rem_o     (rem)
  );

  always_comb begin
    quick    = value_i[W-1] || (value_i < W'(4)) || !value_i[0];
    quot_lt  = quot < d_q;
    rem_zero = rem == '0;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      PR_IDLE: begin
        if (start_i && !quick) begin
          state_d = PR_ISSUE;
        end
      end
      PR_ISSUE: state_d = PR_WAIT;
      PR_WAIT: begin
        if (div_done) begin
          state_d = (quot_lt || rem_zero) ? PR_IDLE : PR_ISSUE;
        end
      end
      default: state_d = PR_IDLE;
    endcase
  end

  always_comb begin
    div_start   = state_q == PR_ISSUE;
    stat_o.busy = state_q != PR_IDLE;
    stat_o.flag = flag_q;
  end

  always_comb begin
    n_d    = n_q;
    d_d    = d_q;
    flag_d = flag_q;
    if (state_q == PR_IDLE && start_i) begin
      n_d    = value_i;
      d_d    = W'(FIRST_DIVISOR);
      flag_d = !value_i[W-1] &&
               (value_i == W'(SMALL_PRIME_LO) || value_i == W'(SMALL_PRIME_HI));
    end else if (state_q == PR_WAIT && div_done) begin
      flag_d = quot_lt;
      d_d    = d_q + W'(DIVISOR_STEP);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    d_q    <= d_d;
    flag_q <= flag_d;
  end

endmodule

### hw/rtl/integer_property_classifier.sv
// Integer property classifier: even, prime and Fibonacci flags per word.
// Usage:
//   Input channel in_valid_i / in_stall_o carries value_i, a signed
//   VALUE_WIDTH-bit word. Output channel out_valid_o / out_stall_i carries
//   is_even_o, is_prime_o and is_fibonacci_o, one result word per input word.
//   One word is in work at a time; in_stall_o stays high from acceptance
//   until the result is loaded into the output register.
//   The Fibonacci unit runs one bit per cycle, one serial addition per term
//   up to the first term not below the value. The prime unit runs one
//   radix-2 serial divide per odd divisor up to the square root. In the
//   prime unit, negative, small and even values finish at once; the
//   Fibonacci unit finishes at once only for negative values.
//   The output register holds a result while out_stall_i is high and the next
//   word may be accepted meanwhile; a finished result then waits in the units.
//   Reset clears all control state; no result is pending after reset.
//   Depends on ipc_pkg, ipc_fib, ipc_prime.
`timescale 1ns / 1ps

module integer_property_classifier import ipc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   is_even_o,
  output logic                   is_prime_o,
  output logic                   is_fibonacci_o
);

  top_state_e state_q, state_d;
  logic       accept;
  logic       load;
  logic       units_done;
  logic       out_free;
  logic       even_q;
  logic       out_valid_q;
  logic       out_even_q;
  logic       out_prime_q;
  logic       out_fib_q;
  unit_stat_t fib_stat;
  unit_stat_t prime_stat;

  ipc_fib #(
    .W(VALUE_WIDTH)
  ) u_ipc_fib (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept),
    .value_i(value_i),
    .stat_o (fib_stat)
  );

  ipc_prime #(
    .W(VALUE_WIDTH)
  ) u_ipc_prime (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept),
    .value_i(value_i),
    .stat_o (prime_stat)
  );

  always_comb begin
    units_done = !fib_stat.busy && !prime_stat.busy;
    out_free   = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      TOP_IDLE: begin
        if (in_valid_i) begin
          state_d = TOP_RUN;
        end
      end
      TOP_RUN: begin
        if (units_done && out_free) begin
          state_d = TOP_IDLE;
        end
      end
      default: state_d = TOP_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = state_q != TOP_IDLE;
    accept     = in_valid_i && state_q == TOP_IDLE;
    load       = state_q == TOP_RUN && units_done && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TOP_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      even_q <= ~value_i[0];
    end
    if (load) begin
      out_even_q  <= even_q;
      out_prime_q <= prime_stat.flag;
      out_fib_q   <= fib_stat.flag;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign is_even_o      = out_even_q;
  assign is_prime_o     = out_prime_q;
  assign is_fibonacci_o = out_fib_q;

endmodule

### hw/rtl/ipc_checker.sv
// Port-level checker for the integer property classifier, bound to the top.
// Depends on assert_macros.svh and integer_property_classifier.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ipc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic is_even_o,
  input logic is_prime_o,
  input logic is_fibonacci_o
);

  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "output word dropped while stalled")
  `ASSERT_CLK(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(is_even_o) && $stable(is_prime_o) && $stable(is_fibonacci_o), "output word changed while stalled")
  `ASSERT_CLK(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o, "input not stalled after accepting a word")
  `ASSERT_CLK(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_stall_o), "result appeared with no word in work")
  `ASSERT_NEVER(a_even_prime_is_two, clk_i, rst_ni, out_valid_o && is_prime_o && is_even_o && !is_fibonacci_o, "even prime reported as non-Fibonacci")

endmodule

bind integer_property_classifier ipc_checker u_ipc_checker (.*);
